### hw/rtl/monotone_polygon_triangulator_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the monotone polygon triangulator
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MONOTONE_POLYGON_TRIANGULATOR_TOP_ASSERT_SVH
`define MONOTONE_POLYGON_TRIANGULATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mpt_pkg.sv
// ---------------------------------------------------------------------------
// mpt_pkg: shared types and constants of the polygon triangulator
// Sizes of the vertex stack and fields, stack entry and control structs.
// ---------------------------------------------------------------------------
`default_nettype none

package mpt_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int COORD_WIDTH = 16;
	localparam int ID_WIDTH    = 16;

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int ORI_W  = PROD_W + 1;

	localparam int S_TDATA_W = ((ID_WIDTH + 2 * COORD_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 * ID_WIDTH + 7) / 8) * 8;

	// One stacked polygon vertex.
	typedef struct packed {
		logic        [ID_WIDTH-1:0]    id;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic                          left;
	} vertex_t;

	// Write port of the vertex stack.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		vertex_t           data;
	} stack_wr_t;

	// Step strobes for the orientation unit.
	typedef struct packed {
		logic load;
		logic mul_p;
		logic mul_q;
	} orient_cmd_t;

	// Sign of the finished orientation value.
	typedef struct packed {
		logic pos;
		logic neg;
	} orient_res_t;

endpackage

`default_nettype wire

### hw/rtl/mpt_stack.sv
// ---------------------------------------------------------------------------
// mpt_stack: vertex stack storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mpt_stack (
	input  wire                      clk,
	input  mpt_pkg::stack_wr_t       wr,
	input  wire [mpt_pkg::ADDR_W-1:0] raddr,
	output mpt_pkg::vertex_t         rdata
);
	import mpt_pkg::*;

	vertex_t mem [STACK_DEPTH];
	vertex_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/mpt_orient.sv
// ---------------------------------------------------------------------------
// mpt_orient: shared orientation unit
// Computes (ax-cx)*(by-cy) - (ay-cy)*(bx-cx) with one multiplier in steps.
// ---------------------------------------------------------------------------
`default_nettype none

module mpt_orient (
	input  wire                  clk,
	input  mpt_pkg::orient_cmd_t cmd,
	input  mpt_pkg::vertex_t     a,
	input  mpt_pkg::vertex_t     b,
	input  mpt_pkg::vertex_t     c,
	output mpt_pkg::orient_res_t res
);
	import mpt_pkg::*;

	logic signed [DIFF_W-1:0] dxa_q, dyb_q, dya_q, dxb_q;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_p_q, prod_q_q;
	logic signed [ORI_W-1:0]  ori;

	// The second step reuses the multiplier for the other cross term.
	assign mul_a = cmd.mul_q ? dya_q : dxa_q;
	assign mul_b = cmd.mul_q ? dxb_q : dyb_q;
	assign prod  = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dxa_q <= {a.x[COORD_WIDTH-1], a.x} - {c.x[COORD_WIDTH-1], c.x};
			dyb_q <= {b.y[COORD_WIDTH-1], b.y} - {c.y[COORD_WIDTH-1], c.y};
			dya_q <= {a.y[COORD_WIDTH-1], a.y} - {c.y[COORD_WIDTH-1], c.y};
			dxb_q <= {b.x[COORD_WIDTH-1], b.x} - {c.x[COORD_WIDTH-1], c.x};
		end
		if (cmd.mul_p) begin
			prod_p_q <= prod;
		end
		if (cmd.mul_q) begin
			prod_q_q <= prod;
		end
	end

	assign ori     = {prod_p_q[PROD_W-1], prod_p_q} - {prod_q_q[PROD_W-1], prod_q_q};
	assign res.neg = ori[ORI_W-1];
	assign res.pos = !ori[ORI_W-1] && (ori != '0);

endmodule

`default_nettype wire

### hw/rtl/monotone_polygon_triangulator_top.sv
// A vertex that only pushes is written straight to the stack; a chain change emits a diagonal
// to every stack entry but the bottom one; a same-chain vertex runs an orientation test per
// pop and releases its last diagonal in a flush step when it pops any; the final vertex emits
// to the inner entries. A stalled receiver stalls the sequencer.
// Input is ready only while the sequencer idles.
// Reset (arst_n low) empties the stack, clears the overflow flag; no clearing pass.
// ---------------------------------------------------------------------------
// monotone_polygon_triangulator_top: stack sweep monotone polygon triangulator
// Takes sorted vertices of a y-monotone polygon and emits diagonal id pairs.
// ---------------------------------------------------------------------------
`default_nettype none
`include "monotone_polygon_triangulator_top_assert.svh"

module monotone_polygon_triangulator_top (
	input  wire                          clk,
	input  wire                          arst_n,
	// Vertex requests.
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire [mpt_pkg::S_TDATA_W-1:0] s_axis_tdata,  // vertex_id, vertex_x, vertex_y
	input  wire                          s_axis_tlast,  // last_vertex
	input  wire                          s_axis_tuser,  // on_left_chain
	// Diagonal requests.
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [mpt_pkg::M_TDATA_W-1:0] m_axis_tdata, // diag_from, diag_to
	output logic                         m_axis_tlast,  // last_of_run
	output logic                         m_axis_tuser   // stack_overflow
);
	import mpt_pkg::*;

	// Sequencer states. The emit loop alternates between a read wait and an
	// emit; the same-chain loop runs the orientation steps for each pop.
	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_RD     = 11'b000_0000_0010,
		ST_EM     = 11'b000_0000_0100,
		ST_DIFF   = 11'b000_0000_1000,
		ST_MUL1   = 11'b000_0001_0000,
		ST_MUL2   = 11'b000_0010_0000,
		ST_CMP    = 11'b000_0100_0000,
		ST_SCEM   = 11'b000_1000_0000,
		ST_PUSH_L = 11'b001_0000_0000,
		ST_PUSH_C = 11'b010_0000_0000,
		ST_FLUSH  = 11'b100_0000_0000
	} state_t;

	// What the current vertex is doing to the stack.
	typedef enum logic [1:0] {
		MODE_FINAL = 2'd0,
		MODE_CHAIN = 2'd1,
		MODE_SAME  = 2'd2
	} mode_t;

	localparam logic [1:0] SEEN_FULL = 2'd2;

	state_t            state_q;
	mode_t             mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        seen_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] idx_q;
	logic              pend_valid_q;
	logic              out_valid_q;

	// Payload registers.
	vertex_t           cur_q;      // vertex being processed
	vertex_t           top_q;      // copy of the stack top
	vertex_t           last_q;     // last popped vertex
	logic [ID_WIDTH-1:0] pend_id_q; // diagonal held back until its successor is known
	logic [ID_WIDTH-1:0] out_from_q, out_to_q;
	logic              out_last_q, out_ovf_q;

	vertex_t           in_vtx;
	vertex_t           rdata;
	stack_wr_t         stack_wr;
	orient_cmd_t       ocmd;
	orient_res_t       ores;

	logic in_accept;
	logic do_final, do_push, do_chain;
	logic push_req, push_fits;
	vertex_t push_data;
	logic out_free, out_load;
	logic em_is_last;
	logic diag_ok;
	logic [ID_WIDTH-1:0] out_from_d;
	logic out_last_d;

	// -----------------------------------------------------------------
	// Input unpacking and dispatch decode
	// -----------------------------------------------------------------
	assign in_vtx.id   = s_axis_tdata[ID_WIDTH-1:0];
	assign in_vtx.x    = s_axis_tdata[ID_WIDTH+COORD_WIDTH-1:ID_WIDTH];
	assign in_vtx.y    = s_axis_tdata[ID_WIDTH+2*COORD_WIDTH-1:ID_WIDTH+COORD_WIDTH];
	assign in_vtx.left = s_axis_tuser;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// The final vertex emits only when at least one inner entry is stacked.
	assign do_final = (seen_q == SEEN_FULL) && (count_q >= CNT_W'(3));
	// Until two vertices are seen, or with an empty stack, a vertex just pushes.
	assign do_push  = !s_axis_tlast && ((seen_q != SEEN_FULL) || (count_q == '0));
	assign do_chain = !s_axis_tlast && !do_push && (in_vtx.left != top_q.left);

	// -----------------------------------------------------------------
	// Stack pushes: a push to a full stack is dropped and flagged.
	// -----------------------------------------------------------------
	always_comb begin
		push_req  = 1'b0;
		push_data = cur_q;
		if (state_q == ST_IDLE) begin
			push_req  = in_accept && do_push;
			push_data = in_vtx;
		end else if (state_q == ST_PUSH_L) begin
			push_req  = 1'b1;
			push_data = last_q;
		end else if (state_q == ST_PUSH_C) begin
			push_req  = 1'b1;
		end
	end

	assign push_fits     = (count_q < CNT_W'(STACK_DEPTH));
	assign stack_wr.en   = push_req && push_fits;
	assign stack_wr.addr = count_q[ADDR_W-1:0];
	assign stack_wr.data = push_data;

	mpt_stack u_stack (
		.clk   (clk),
		.wr    (stack_wr),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// -----------------------------------------------------------------
	// Orientation unit: a = last popped, b = current, c = entry below it.
	// -----------------------------------------------------------------
	assign ocmd.load  = (state_q == ST_DIFF);
	assign ocmd.mul_p = (state_q == ST_MUL1);
	assign ocmd.mul_q = (state_q == ST_MUL2);

	mpt_orient u_orient (
		.clk (clk),
		.cmd (ocmd),
		.a   (last_q),
		.b   (cur_q),
		.c   (rdata),
		.res (ores)
	);

	// The diagonal lies inside for a positive turn on the left chain and a
	// negative one on the right chain.
	assign diag_ok = cur_q.left ? ores.pos : ores.neg;

	// -----------------------------------------------------------------
	// Output register. It may hold a diagonal while the next vertex is taken.
	// -----------------------------------------------------------------
	assign out_free = !out_valid_q || m_axis_tready;

	// The final vertex walks the stack down to entry one; a chain change
	// walks it up to the top.
	assign em_is_last = (mode_q == MODE_FINAL) ? (idx_q == ADDR_W'(1))
	                                           : (CNT_W'(idx_q) == count_q - CNT_W'(1));

	always_comb begin
		out_load   = 1'b0;
		out_from_d = pend_id_q;
		out_last_d = 1'b0;
		if (state_q == ST_EM) begin
			out_load   = out_free;
			out_from_d = rdata.id;
			out_last_d = em_is_last;
		end else if (state_q == ST_SCEM) begin
			out_load   = out_free && pend_valid_q;
		end else if (state_q == ST_FLUSH) begin
			out_load   = out_free;
			out_last_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_from_q <= out_from_d;
			out_to_q   <= cur_q.id;
			out_last_q <= out_last_d;
			out_ovf_q  <= ovf_q;
		end
	end

	always_comb begin
		m_axis_tdata                   = '0;
		m_axis_tdata[2*ID_WIDTH-1:0]   = {out_to_q, out_from_q};
	end
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

	// -----------------------------------------------------------------
	// Payload registers of the sequencer
	// -----------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cur_q <= in_vtx;
		end
		if (push_req && push_fits) begin
			top_q <= push_data;
		end
		if (in_accept && !s_axis_tlast && !do_push) begin
			last_q <= top_q;
		end else if (state_q == ST_SCEM && (out_free || !pend_valid_q)) begin
			last_q    <= rdata;
		end
		if (state_q == ST_SCEM && (out_free || !pend_valid_q)) begin
			pend_id_q <= rdata.id;
		end
	end

	// -----------------------------------------------------------------
	// Sequencer
	// -----------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_FINAL;
			count_q      <= '0;
			seen_q       <= '0;
			ovf_q        <= 1'b0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (push_req) begin
				if (push_fits) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (s_axis_tlast) begin
							if (do_final) begin
								mode_q  <= MODE_FINAL;
								idx_q   <= ADDR_W'(count_q - CNT_W'(2));
								state_q <= ST_RD;
							end else begin
								count_q <= '0;
								seen_q  <= '0;
							end
						end else if (do_push) begin
							if (seen_q != SEEN_FULL) begin
								seen_q <= seen_q + 2'd1;
							end
						end else if (do_chain) begin
							mode_q <= MODE_CHAIN;
							if (count_q >= CNT_W'(2)) begin
								idx_q   <= ADDR_W'(1);
								state_q <= ST_RD;
							end else begin
								count_q <= '0;
								state_q <= ST_PUSH_L;
							end
						end else begin
							// Same chain: pop the top, then test the entry below.
							mode_q  <= MODE_SAME;
							count_q <= count_q - CNT_W'(1);
							if (count_q > CNT_W'(1)) begin
								idx_q   <= ADDR_W'(count_q - CNT_W'(2));
								state_q <= ST_RD;
							end else begin
								state_q <= ST_PUSH_L;
							end
						end
					end
				end
				ST_RD: begin
					state_q <= (mode_q == MODE_SAME) ? ST_DIFF : ST_EM;
				end
				ST_EM: begin
					if (out_free) begin
						if (em_is_last) begin
							count_q <= '0;
							if (mode_q == MODE_FINAL) begin
								seen_q  <= '0;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_PUSH_L;
							end
						end else begin
							idx_q   <= (mode_q == MODE_FINAL) ? idx_q - ADDR_W'(1)
							                                  : idx_q + ADDR_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_DIFF: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= diag_ok ? ST_SCEM : ST_PUSH_L;
				end
				ST_SCEM: begin
					// A held diagonal goes out now that another one follows it.
					if (out_free || !pend_valid_q) begin
						pend_valid_q <= 1'b1;
						count_q      <= count_q - CNT_W'(1);
						if (count_q > CNT_W'(1)) begin
							idx_q   <= ADDR_W'(count_q - CNT_W'(2));
							state_q <= ST_RD;
						end else begin
							state_q <= ST_PUSH_L;
						end
					end
				end
				ST_PUSH_L: begin
					state_q <= ST_PUSH_C;
				end
				ST_PUSH_C: begin
					state_q <= pend_valid_q ? ST_FLUSH : ST_IDLE;
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// -----------------------------------------------------------------
	// Assertions
	// -----------------------------------------------------------------
	`MPT_ASSERT_NXT(a_ovf_sticky, ovf_q, ovf_q, "overflow flag cleared after being set")
	`MPT_ASSERT_IMP(a_out_load_free, out_load, !out_valid_q || m_axis_tready,
		"output register overwritten while a diagonal waits")
	`MPT_ASSERT_IMP(a_pend_same, pend_valid_q, mode_q == MODE_SAME,
		"held diagonal outside a same-chain pop run")
	`MPT_ASSERT_IMP(a_em_index, state_q == ST_EM, (idx_q != '0) && (CNT_W'(idx_q) < count_q),
		"emitted entry outside the inner stack range")

endmodule

`default_nettype wire

### dv/diagonal_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diagonal_checker: predicts and checks the triangulator's diagonal stream
// Watches both channels, runs its own stack sweep on every vertex request
// and compares each diagonal request with the oldest predicted diagonal.
// ---------------------------------------------------------------------------

module diagonal_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_axis_tvalid,
	input  wire                          s_axis_tready,
	input  wire [mpt_pkg::S_TDATA_W-1:0] s_axis_tdata,  // vertex_id, vertex_x, vertex_y
	input  wire                          s_axis_tlast,  // last_vertex
	input  wire                          s_axis_tuser,  // on_left_chain
	input  wire                          m_axis_tvalid,
	input  wire                          m_axis_tready,
	input  wire [mpt_pkg::M_TDATA_W-1:0] m_axis_tdata,  // diag_from, diag_to
	input  wire                          m_axis_tlast,  // last_of_run
	input  wire                          m_axis_tuser,  // stack_overflow
	output int unsigned                  fail_count,
	output int unsigned                  pending
);

	import mpt_pkg::*;

	typedef struct {
		logic [ID_WIDTH-1:0] from_id;
		logic [ID_WIDTH-1:0] to_id;
		bit                  run_end;
		bit                  overflow;
	} diagonal_t;

	vertex_t     sweep_stack [STACK_DEPTH];
	int          depth;
	int          seen;
	bit          overflow_seen;
	diagonal_t   expected_diagonals [$];
	int unsigned fails;

	// Exact orientation of (pivot, cur) against the stack top, in 64 bits.
	function automatic bit diagonal_inside(vertex_t pivot, vertex_t cur, vertex_t top_v);
		longint ax, ay, bx, by, cx, cy, o;
		ax = longint'($signed(pivot.x));
		ay = longint'($signed(pivot.y));
		bx = longint'($signed(cur.x));
		by = longint'($signed(cur.y));
		cx = longint'($signed(top_v.x));
		cy = longint'($signed(top_v.y));
		o  = (ax - cx) * (by - cy) - (ay - cy) * (bx - cx);
		return cur.left ? (o > 0) : (o < 0);
	endfunction

	task automatic push_vertex(input vertex_t v);
		if (depth < STACK_DEPTH) begin
			sweep_stack[depth] = v;
			depth++;
		end else begin
			overflow_seen = 1'b1;
		end
	endtask

	task automatic triangulate_vertex(input vertex_t cur, input bit closes);
		diagonal_t run [$];
		diagonal_t item;
		vertex_t   pivot;
		if (closes) begin
			if (seen >= 2 && depth >= 3)
				for (int i = depth - 2; i >= 1; i--) begin
					item = '{sweep_stack[i].id, cur.id, 1'b0, 1'b0};
					run.insert(run.size(), item);
				end
			depth = 0;
			seen  = 0;
		end else if (seen < 2 || depth == 0) begin
			push_vertex(cur);
			if (seen < 2)
				seen++;
		end else if (cur.left != sweep_stack[depth-1].left) begin
			// Chain change: fan out to everything but the bottom entry.
			pivot = sweep_stack[depth-1];
			for (int i = 1; i < depth; i++) begin
				item = '{sweep_stack[i].id, cur.id, 1'b0, 1'b0};
				run.insert(run.size(), item);
			end
			depth = 0;
			push_vertex(pivot);
			push_vertex(cur);
		end else begin
			pivot = sweep_stack[depth-1];
			depth--;
			while (depth > 0 && diagonal_inside(pivot, cur, sweep_stack[depth-1])) begin
				pivot = sweep_stack[depth-1];
				depth--;
				item = '{pivot.id, cur.id, 1'b0, 1'b0};
				run.insert(run.size(), item);
			end
			push_vertex(pivot);
			push_vertex(cur);
		end
		// The flag reported is the one standing after the whole vertex.
		foreach (run[k]) begin
			run[k].overflow = overflow_seen;
			run[k].run_end  = (k == run.size() - 1);
			expected_diagonals.insert(expected_diagonals.size(), run[k]);
		end
	endtask

	task automatic check_field(input string field, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: diagonal %s mismatch, expected %0h, actual %0h",
				$time, field, want, got);
			fails++;
		end
	endtask

	task automatic check_diagonal();
		diagonal_t want;
		if (expected_diagonals.size() == 0) begin
			$display("%0t: unexpected diagonal, expected none, actual %0h -> %0h last %0b ovf %0b",
				$time, m_axis_tdata[ID_WIDTH-1:0], m_axis_tdata[2*ID_WIDTH-1:ID_WIDTH],
				m_axis_tlast, m_axis_tuser);
			fails++;
		end else begin
			want = expected_diagonals.pop_front();
			check_field("from", want.from_id, m_axis_tdata[ID_WIDTH-1:0]);
			check_field("to", want.to_id, m_axis_tdata[2*ID_WIDTH-1:ID_WIDTH]);
			check_field("last_of_run", want.run_end, m_axis_tlast);
			check_field("stack_overflow", want.overflow, m_axis_tuser);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_t v;
		if (!arst_n) begin
			depth         = 0;
			seen          = 0;
			overflow_seen = 1'b0;
			fails         = 0;
			expected_diagonals.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// Predict first, so a same-edge result could never beat its vertex.
			if (s_axis_tvalid && s_axis_tready) begin
				v.id   = s_axis_tdata[ID_WIDTH-1:0];
				v.x    = s_axis_tdata[ID_WIDTH +: COORD_WIDTH];
				v.y    = s_axis_tdata[ID_WIDTH+COORD_WIDTH +: COORD_WIDTH];
				v.left = s_axis_tuser;
				triangulate_vertex(v, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready)
				check_diagonal();
			fail_count <= fails;
			pending    <= expected_diagonals.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the monotone polygon triangulator
// Streams directed, random and overflow polygons into the block with random
// idling on both sides; a separate checker predicts and compares diagonals.
// ---------------------------------------------------------------------------

module testbench;

	import mpt_pkg::*;

	// A long receiver hold must fill the block and stall vertex requests.
	localparam int HOLD_CYCLES    = 400;
	// Worst vertex: 63 diagonals, each one with its own orientation work.
	localparam int SETTLE_CYCLES  = 500;
	localparam int WATCHDOG_LIMIT = 4000;
	// Random phase; with the directed and full-stack vertices the run is about 420.
	localparam int RANDOM_ITEMS   = 260;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // vertex_id, vertex_x, vertex_y
	logic                  s_axis_tlast  = 1'b0; // last_vertex
	logic                  s_axis_tuser  = 1'b0; // on_left_chain
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;         // diag_from, diag_to
	logic                  m_axis_tlast;         // last_of_run
	logic                  m_axis_tuser;         // stack_overflow

	int unsigned fail_count;
	int unsigned pending;

	// Idling is switched per polygon; the hold is asked once by the stimulus.
	bit idle_enable  = 1'b1;
	bit hold_request = 1'b0;
	bit hold_done    = 1'b0;
	int items_sent   = 0;

	wire any_request = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);

	always #1 clk = ~clk;

	monotone_polygon_triangulator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	diagonal_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Offer one vertex request and return once it has been taken. A random gap
	// may come first; valid is only lowered when such a gap really happens, so
	// back-to-back requests keep it high without a second assignment.
	task automatic send_vertex(input logic [ID_WIDTH-1:0] id, input logic [COORD_WIDTH-1:0] x,
			input logic [COORD_WIDTH-1:0] y, input bit left, input bit last);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tdata  <= S_TDATA_W'({y, x, id});
		s_axis_tlast  <= last;
		s_axis_tuser  <= left;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Sender pause: drop valid, wait for every predicted diagonal, then give
	// the block time to finish any vertex that produces nothing.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A genuine y-monotone polygon: y strictly falls, left-chain vertices sit in
	// the negative x half and right-chain ones in the positive half. Chains run
	// in stretches so that reflex chains build up and get popped.
	task automatic send_monotone_polygon(input int count);
		int ycur;
		bit left;
		logic [COORD_WIDTH-1:0] xv;
		ycur = 32767 - $urandom_range(0, 8191);
		left = $urandom_range(0, 1);
		for (int k = 0; k < count; k++) begin
			if (k > 0 && $urandom_range(0, 9) < 3)
				left = !left;
			xv = left ? COORD_WIDTH'(int'($urandom_range(0, 32767)) - 32768)
				: COORD_WIDTH'($urandom_range(0, 32767));
			send_vertex(ID_WIDTH'($urandom), xv, COORD_WIDTH'(ycur), left, k == count - 1);
			ycur -= $urandom_range(1, 50000 / count);
		end
	endtask

	// Unordered vertices with random fields; the run may close early on its own.
	task automatic send_noise_run(input int count);
		bit closes;
		for (int k = 0; k < count; k++) begin
			closes = (k == count - 1) || ($urandom_range(0, 7) == 0);
			send_vertex(ID_WIDTH'($urandom), COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
				$urandom_range(0, 1), closes);
		end
	endtask

	// Diagonal receiver: random stalls, ready stretches, and one long hold.
	initial begin : diag_receiver
		int span;
		@(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (idle_enable && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				span = idle_enable ? $urandom_range(1, 24) : 1;
				repeat (span) @(posedge clk);
			end
		end
	end

	// Ends the run when neither channel has moved a request for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (any_request)
				quiet = 0;
			else
				quiet++;
		end
		$display("** monotone_polygon_triangulator_top: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int pick;
		int count;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short polygon closed by its very first vertex, all fields at extremes.
		send_vertex(16'hFFFF, 16'h8000, 16'h7FFF, 1'b1, 1'b1);
		// Short polygon closed by its second vertex.
		send_vertex(16'h0000, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
		send_vertex(16'h0001, 16'hFFFF, 16'h8000, 1'b1, 1'b1);
		// A triangle needs no diagonal at all.
		send_vertex(16'h0002, 16'd0, 16'd100, 1'b1, 1'b0);
		send_vertex(16'h0003, 16'd20, 16'd50, 1'b0, 1'b0);
		send_vertex(16'h0004, 16'd0, 16'd0, 1'b1, 1'b1);
		// Chain change, a same-chain pop and a fan-out from the last vertex.
		send_vertex(16'h0010, 16'd0, 16'd100, 1'b1, 1'b0);
		send_vertex(16'h0011, -16'sd50, 16'd90, 1'b1, 1'b0);
		send_vertex(16'h0012, 16'd50, 16'd80, 1'b0, 1'b0);
		send_vertex(16'h0013, 16'd60, 16'd70, 1'b0, 1'b0);
		send_vertex(16'h0014, -16'sd40, 16'd60, 1'b1, 1'b0);
		send_vertex(16'h0015, 16'd0, 16'd0, 1'b1, 1'b1);
		// Same-chain test on full-scale coordinates where the diagonal is outside.
		send_vertex(16'h0100, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
		send_vertex(16'h0101, 16'h8000, 16'h0000, 1'b0, 1'b0);
		send_vertex(16'h0102, 16'h7FFF, 16'h8001, 1'b0, 1'b0);
		send_vertex(16'h0103, 16'h0000, 16'h8000, 1'b1, 1'b1);
		// Same test, mirrored, where the diagonal is inside and gets popped.
		send_vertex(16'h0200, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
		send_vertex(16'h0201, 16'h7FFF, 16'h0000, 1'b0, 1'b0);
		send_vertex(16'h0202, 16'h8000, 16'h8001, 1'b0, 1'b0);
		send_vertex(16'h0203, 16'h0000, 16'h8000, 1'b1, 1'b1);
		settle();

		// Random polygons. The long receiver hold starts with this phase while
		// the sender keeps going, so the block backs up into its input.
		hold_request = 1'b1;
		items_sent   = 0;
		while (items_sent < RANDOM_ITEMS) begin
			idle_enable = ($urandom_range(0, 4) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 10)
				count = $urandom_range(1, 2);
			else if (pick < 80)
				count = $urandom_range(3, 10);
			else
				count = $urandom_range(11, 24);
			if ($urandom_range(0, 3) == 0)
				send_noise_run(count);
			else
				send_monotone_polygon(count);
		end
		idle_enable = 1'b1;
		settle();

		// Full stack, at the end since the overflow flag never clears. A straight
		// left chain never passes the orientation test, so the stack only grows.
		idle_enable = 1'b0;
		for (int k = 0; k < 70; k++)
			send_vertex(ID_WIDTH'(k), 16'd0, COORD_WIDTH'(1000 - 10 * k), 1'b1, 1'b0);
		// Chain change at a full stack fans out to 63 entries.
		send_vertex(16'hBEEF, 16'd500, -16'sd100, 1'b0, 1'b0);
		send_vertex(16'hBEF0, -16'sd500, -16'sd200, 1'b1, 1'b1);
		// A full stack closed directly by the last vertex.
		for (int k = 0; k < 70; k++)
			send_vertex(ID_WIDTH'(16'h8000 + k), -16'sd7, COORD_WIDTH'(30000 - 100 * k),
				1'b0, 1'b0);
		send_vertex(16'hFFFF, 16'd3, -16'sd20000, 1'b0, 1'b1);
		settle();

		if (fail_count == 0 && pending == 0)
			$display("** monotone_polygon_triangulator_top: PASSED **");
		else
			$display("** monotone_polygon_triangulator_top: FAILED **");
		$finish;
	end

endmodule
